// ===== sv/scet_pkg.sv =====
// Package for the swept circle edge test: coordinate widths and derived
// arithmetic widths. No dependencies.
`default_nettype none
package scet_pkg;
  localparam int COORD_WIDTH = 24;
  localparam int RAD_WIDTH   = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH + 1;
  localparam int SQ_WIDTH    = PROD_WIDTH + 1;
  localparam int R2_WIDTH    = 2 * RAD_WIDTH;
  // c*c and r2*den products
  localparam int BIG_WIDTH   = 2 * SQ_WIDTH + 2;
  // magnitude of c and den, split in halves for the partial products
  localparam int MAG_WIDTH   = SQ_WIDTH - 1;
  localparam int LO_WIDTH    = (MAG_WIDTH + 1) / 2;
  localparam int HI_WIDTH    = MAG_WIDTH - LO_WIDTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [SQ_WIDTH-1:0]    sq_t;
  typedef logic signed [BIG_WIDTH-1:0]   big_t;
endpackage
`default_nettype wire

// ===== sv/scet_near.sv =====
// Pipelined point-to-segment distance test, five register stages.
// Depends on scet_pkg.
`default_nettype none
module scet_near (
  input  wire logic                           clk,
  input  wire scet_pkg::coord_t               px,
  input  wire scet_pkg::coord_t               pz,
  input  wire scet_pkg::coord_t               ax,
  input  wire scet_pkg::coord_t               az,
  input  wire scet_pkg::coord_t               bx,
  input  wire scet_pkg::coord_t               bz,
  input  wire logic [scet_pkg::R2_WIDTH-1:0]  r2,
  output logic                                near
);
  import scet_pkg::*;

  // stage 1: differences
  diff_t ux, uz, vx, vz, wx, wz;
  logic [R2_WIDTH-1:0] r2_1;
  always_ff @(posedge clk) begin
    ux <= DIFF_WIDTH'(bx) - DIFF_WIDTH'(ax);
    uz <= DIFF_WIDTH'(bz) - DIFF_WIDTH'(az);
    vx <= DIFF_WIDTH'(px) - DIFF_WIDTH'(ax);
    vz <= DIFF_WIDTH'(pz) - DIFF_WIDTH'(az);
    wx <= DIFF_WIDTH'(px) - DIFF_WIDTH'(bx);
    wz <= DIFF_WIDTH'(pz) - DIFF_WIDTH'(bz);
    r2_1 <= r2;
  end

  // stage 2: one product per term
  sq_t p_uxux, p_uzuz, p_vxux, p_vzuz, p_vxuz, p_vzux, p_vxvx, p_vzvz, p_wxwx, p_wzwz;
  logic [R2_WIDTH-1:0] r2_2;
  always_ff @(posedge clk) begin
    p_uxux <= SQ_WIDTH'(ux * ux);
    p_uzuz <= SQ_WIDTH'(uz * uz);
    p_vxux <= SQ_WIDTH'(vx * ux);
    p_vzuz <= SQ_WIDTH'(vz * uz);
    p_vxuz <= SQ_WIDTH'(vx * uz);
    p_vzux <= SQ_WIDTH'(vz * ux);
    p_vxvx <= SQ_WIDTH'(vx * vx);
    p_vzvz <= SQ_WIDTH'(vz * vz);
    p_wxwx <= SQ_WIDTH'(wx * wx);
    p_wzwz <= SQ_WIDTH'(wz * wz);
    r2_2 <= r2_1;
  end

  // stage 3: sums, magnitudes and endpoint decisions
  logic [MAG_WIDTH-1:0] den_mag, c_mag;
  logic sel_a, sel_b, near_a, near_b;
  logic [R2_WIDTH-1:0] r2_3;
  sq_t num_c, la_c, lb_c, den_c, c_c;
  always_comb begin
    den_c = p_uxux + p_uzuz;
    num_c = p_vxux + p_vzuz;
    la_c  = p_vxvx + p_vzvz;
    lb_c  = p_wxwx + p_wzwz;
    c_c   = p_vxuz - p_vzux;
  end
  always_ff @(posedge clk) begin
    den_mag <= den_c[MAG_WIDTH-1:0];
    c_mag   <= c_c[SQ_WIDTH-1] ? MAG_WIDTH'(-c_c) : c_c[MAG_WIDTH-1:0];
    sel_a   <= (den_c == '0) || (num_c <= 0);
    sel_b   <= !(num_c < den_c);
    near_a  <= la_c < $signed({1'b0, r2_2});
    near_b  <= lb_c < $signed({1'b0, r2_2});
    r2_3    <= r2_2;
  end

  // stage 4: half-width partial products of c*c and r2*den
  logic [2*HI_WIDTH-1:0]         cc_hh;
  logic [HI_WIDTH+LO_WIDTH-1:0]  cc_hl;
  logic [2*LO_WIDTH-1:0]         cc_ll;
  logic [R2_WIDTH+HI_WIDTH-1:0]  rd_h;
  logic [R2_WIDTH+LO_WIDTH-1:0]  rd_l;
  logic sel_a4, sel_b4, near_a4, near_b4;
  always_ff @(posedge clk) begin
    cc_hh   <= (2*HI_WIDTH)'(c_mag[MAG_WIDTH-1:LO_WIDTH] * c_mag[MAG_WIDTH-1:LO_WIDTH]);
    cc_hl   <= (HI_WIDTH+LO_WIDTH)'(c_mag[MAG_WIDTH-1:LO_WIDTH] * c_mag[LO_WIDTH-1:0]);
    cc_ll   <= (2*LO_WIDTH)'(c_mag[LO_WIDTH-1:0] * c_mag[LO_WIDTH-1:0]);
    rd_h    <= (R2_WIDTH+HI_WIDTH)'(r2_3 * den_mag[MAG_WIDTH-1:LO_WIDTH]);
    rd_l    <= (R2_WIDTH+LO_WIDTH)'(r2_3 * den_mag[LO_WIDTH-1:0]);
    sel_a4  <= sel_a;
    sel_b4  <= sel_b;
    near_a4 <= near_a;
    near_b4 <= near_b;
  end

  // stage 5: recombine the partial products
  big_t cc, rd;
  logic sel_a5, sel_b5, near_a5, near_b5;
  always_ff @(posedge clk) begin
    cc      <= (BIG_WIDTH'(cc_hh) << (2*LO_WIDTH)) + (BIG_WIDTH'(cc_hl) << (LO_WIDTH+1)) +
               BIG_WIDTH'(cc_ll);
    rd      <= (BIG_WIDTH'(rd_h) << LO_WIDTH) + BIG_WIDTH'(rd_l);
    sel_a5  <= sel_a4;
    sel_b5  <= sel_b4;
    near_a5 <= near_a4;
    near_b5 <= near_b4;
  end

  assign near = sel_a5 ? near_a5 : (sel_b5 ? near_b5 : (cc < rd));
endmodule
`default_nettype wire

// ===== sv/swept_circle_edge_test_top.sv =====
// Top level of the swept circle edge test. Depends on scet_pkg and
// scet_near.
`default_nettype none
// Takes one move and one edge per cycle (busy is always low) and returns
// reaches/crossed with done high for one cycle. The latency is set by the
// five-stage distance pipeline in scet_near (the wide perpendicular
// products are split into half-width partial products over two stages)
// plus the output register; the receiver cannot stall, and none is needed
// since every beat moves forward each cycle. The radius register is sampled
// when a beat enters, so write it only while idle.
// Distance tests are exact integer comparisons of squared distances.
module swept_circle_edge_test_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire scet_pkg::coord_t                start_x,
  input  wire scet_pkg::coord_t                start_z,
  input  wire scet_pkg::coord_t                end_x,
  input  wire scet_pkg::coord_t                end_z,
  input  wire scet_pkg::coord_t                edge_a_x,
  input  wire scet_pkg::coord_t                edge_a_z,
  input  wire scet_pkg::coord_t                edge_b_x,
  input  wire scet_pkg::coord_t                edge_b_z,
  input  wire logic                            cfg_we,
  input  wire logic [scet_pkg::RAD_WIDTH-1:0]  cfg_data,
  output logic                                 done,
  output logic                                 reaches,
  output logic                                 crossed
);
  import scet_pkg::*;

  localparam int LAT = 5;

  logic [RAD_WIDTH-1:0] circle_radius;
  logic [R2_WIDTH-1:0]  r2;
  logic [LAT-1:0]       vld;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      circle_radius <= RAD_WIDTH'(100);
    end else if (cfg_we) begin
      circle_radius <= cfg_data;
    end
  end
  assign r2 = circle_radius * circle_radius;

  // three distance tests run side by side
  logic near_end, near_a, near_b;
  scet_near u_end (.clk, .px(end_x), .pz(end_z), .ax(edge_a_x), .az(edge_a_z),
                   .bx(edge_b_x), .bz(edge_b_z), .r2, .near(near_end));
  scet_near u_a (.clk, .px(edge_a_x), .pz(edge_a_z), .ax(start_x), .az(start_z),
                 .bx(end_x), .bz(end_z), .r2, .near(near_a));
  scet_near u_b (.clk, .px(edge_b_x), .pz(edge_b_z), .ax(start_x), .az(start_z),
                 .bx(end_x), .bz(end_z), .r2, .near(near_b));

  // crossing test: stage 1 differences, stage 2 products, stage 3 signs,
  // stages 4 and 5 hold the decision in line with the distance tests
  diff_t mx, mz, ex, ez, d_ca_x, d_ca_z, d_cb_x, d_cb_z, d_as_x, d_as_z, d_bs_x, d_bs_z;
  always_ff @(posedge clk) begin
    ex     <= DIFF_WIDTH'(edge_b_x) - DIFF_WIDTH'(edge_a_x);
    ez     <= DIFF_WIDTH'(edge_b_z) - DIFF_WIDTH'(edge_a_z);
    d_ca_x <= DIFF_WIDTH'(start_x) - DIFF_WIDTH'(edge_a_x);
    d_ca_z <= DIFF_WIDTH'(start_z) - DIFF_WIDTH'(edge_a_z);
    d_cb_x <= DIFF_WIDTH'(end_x) - DIFF_WIDTH'(edge_a_x);
    d_cb_z <= DIFF_WIDTH'(end_z) - DIFF_WIDTH'(edge_a_z);
    mx     <= DIFF_WIDTH'(end_x) - DIFF_WIDTH'(start_x);
    mz     <= DIFF_WIDTH'(end_z) - DIFF_WIDTH'(start_z);
    d_as_x <= DIFF_WIDTH'(edge_a_x) - DIFF_WIDTH'(start_x);
    d_as_z <= DIFF_WIDTH'(edge_a_z) - DIFF_WIDTH'(start_z);
    d_bs_x <= DIFF_WIDTH'(edge_b_x) - DIFF_WIDTH'(start_x);
    d_bs_z <= DIFF_WIDTH'(edge_b_z) - DIFF_WIDTH'(start_z);
  end

  sq_t q1a, q1b, q2a, q2b, q3a, q3b, q4a, q4b;
  always_ff @(posedge clk) begin
    q1a <= SQ_WIDTH'(ex * d_ca_z);
    q1b <= SQ_WIDTH'(ez * d_ca_x);
    q2a <= SQ_WIDTH'(ex * d_cb_z);
    q2b <= SQ_WIDTH'(ez * d_cb_x);
    q3a <= SQ_WIDTH'(mx * d_as_z);
    q3b <= SQ_WIDTH'(mz * d_as_x);
    q4a <= SQ_WIDTH'(mx * d_bs_z);
    q4b <= SQ_WIDTH'(mz * d_bs_x);
  end

  logic cross3, cross4, cross5;
  sq_t o1, o2, o3, o4;
  always_comb begin
    o1 = q1a - q1b;
    o2 = q2a - q2b;
    o3 = q3a - q3b;
    o4 = q4a - q4b;
  end
  always_ff @(posedge clk) begin
    cross3 <= (o1 == '0) || (o2 == '0) || (o3 == '0) || (o4 == '0) ||
              ((o1[SQ_WIDTH-1] != o2[SQ_WIDTH-1]) && (o3[SQ_WIDTH-1] != o4[SQ_WIDTH-1]));
    cross4 <= cross3;
    cross5 <= cross4;
  end

  // valid bits travel alongside the five data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LAT-2:0], start};
      done <= vld[LAT-1];
    end
  end

  // first test that holds decides; crossed only when the crossing test decides
  always_ff @(posedge clk) begin
    reaches <= near_end || cross5 || near_a || near_b;
    crossed <= !near_end && cross5;
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_swept_circle_edge_test_top.sv =====
// Self-checking testbench for swept_circle_edge_test_top: directed table, then
// random moves and edges under several radius settings and idle patterns.
// Depends on scet_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_swept_circle_edge_test_top;
  import scet_pkg::*;

  typedef logic signed [127:0] acc_t;
  typedef struct {
    coord_t sx, sz, ex, ez, ax, az, bx, bz;
  } probe_t;
  typedef struct {
    bit reaches;
    bit crossed;
  } hit_t;
  typedef struct {
    probe_t p;
    bit     known;
    hit_t   want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic cfg_we = 1'b0;
  logic [RAD_WIDTH-1:0] cfg_data = '0;
  coord_t start_x = '0, start_z = '0, end_x = '0, end_z = '0;
  coord_t edge_a_x = '0, edge_a_z = '0, edge_b_x = '0, edge_b_z = '0;
  logic busy, done, reaches, crossed;

  hit_t hit_q[$];
  int   fail_count = 0;
  int   beats_sent = 0;
  int   hits_seen = 0;
  int   cross_seen = 0;
  int   idle_pct = 0;
  logic [RAD_WIDTH-1:0] radius = 16'd100;

  swept_circle_edge_test_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .start_x(start_x), .start_z(start_z), .end_x(end_x), .end_z(end_z),
    .edge_a_x(edge_a_x), .edge_a_z(edge_a_z),
    .edge_b_x(edge_b_x), .edge_b_z(edge_b_z),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done), .reaches(reaches), .crossed(crossed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block never answers.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic acc_t sqlen(input longint x, input longint z);
    acc_t ax, az;
    ax = x;
    az = z;
    return ax * ax + az * az;
  endfunction

  // Squared distance from P to segment AB strictly below r2, exact.
  function automatic bit point_near_segment(input longint px, input longint pz,
      input longint ax, input longint az, input longint bx, input longint bz,
      input acc_t r2);
    acc_t ux, uz, vx, vz, den, num, c;
    ux = bx - ax;
    uz = bz - az;
    vx = px - ax;
    vz = pz - az;
    den = ux * ux + uz * uz;
    num = vx * ux + vz * uz;
    if (den == 0 || num <= 0) return sqlen(px - ax, pz - az) < r2;
    if (num >= den) return sqlen(px - bx, pz - bz) < r2;
    c = vx * uz - vz * ux;
    return c * c < r2 * den;
  endfunction

  function automatic acc_t orientation(input longint ax, input longint az,
      input longint bx, input longint bz, input longint px, input longint pz);
    acc_t dx1, dz1, dx2, dz2;
    dx1 = bx - ax;
    dz1 = bz - az;
    dx2 = px - ax;
    dz2 = pz - az;
    return dx1 * dz2 - dz1 * dx2;
  endfunction

  function automatic hit_t sweep_hits_edge(input probe_t p,
                                           input logic [RAD_WIDTH-1:0] r);
    longint sx, sz, ex, ez, ax, az, bx, bz;
    acc_t r2, d1, d2, d3, d4;
    hit_t h;
    sx = p.sx; sz = p.sz; ex = p.ex; ez = p.ez;
    ax = p.ax; az = p.az; bx = p.bx; bz = p.bz;
    r2 = acc_t'(r) * acc_t'(r);
    h = '{0, 0};
    d1 = orientation(ax, az, bx, bz, sx, sz);
    d2 = orientation(ax, az, bx, bz, ex, ez);
    d3 = orientation(sx, sz, ex, ez, ax, az);
    d4 = orientation(sx, sz, ex, ez, bx, bz);
    if (point_near_segment(ex, ez, ax, az, bx, bz, r2)) begin
      h.reaches = 1;
    end else if (d1 == 0 || d2 == 0 || d3 == 0 || d4 == 0 ||
                 ((d1 < 0) != (d2 < 0) && (d3 < 0) != (d4 < 0))) begin
      h.reaches = 1;
      h.crossed = 1;
    end else if (point_near_segment(ax, az, sx, sz, ex, ez, r2) ||
                 point_near_segment(bx, bz, sx, sz, ex, ez, r2)) begin
      h.reaches = 1;
    end
    return h;
  endfunction

  // Compare every result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (hit_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        hit_t w;
        w = hit_q.pop_front();
        if (reaches !== w.reaches)
          report_mismatch($sformatf("reaches %b, expected %b", reaches, w.reaches));
        if (crossed !== w.crossed)
          report_mismatch($sformatf("crossed %b, expected %b", crossed, w.crossed));
        hits_seen += w.reaches;
        cross_seen += w.crossed;
      end
    end
  end

  // Drive one beat at the falling edge, hold it until taken, then maybe idle.
  task automatic send_beat(input probe_t p);
    @(negedge clk);
    start <= 1'b1;
    start_x <= p.sx; start_z <= p.sz; end_x <= p.ex; end_z <= p.ez;
    edge_a_x <= p.ax; edge_a_z <= p.az; edge_b_x <= p.bx; edge_b_z <= p.bz;
    do @(posedge clk); while (busy);
    hit_q.push_back(sweep_hits_edge(p, radius));
    beats_sent++;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Stop sending and wait for every result plus the pipeline depth.
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_radius(input logic [RAD_WIDTH-1:0] r);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= r;
    @(negedge clk);
    cfg_we <= 1'b0;
    radius = r;
  endtask

  function automatic coord_t near_val(input longint base, input int spread);
    longint v;
    v = base + longint'($urandom_range(0, 2 * spread)) - spread;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return coord_t'(v);
  endfunction

  // Mostly clustered geometry at the scale of the radius, so every test
  // decides sometimes; plus full-range noise, collinear moves, zero-length moves and edges.
  function automatic probe_t random_probe();
    probe_t p;
    longint cx, cz;
    int s, mode;
    s = int'(radius) * 3 + 20;
    if (s > 400000) s = 400000;
    cx = $signed(coord_t'($urandom));
    cz = $signed(coord_t'($urandom));
    mode = $urandom_range(0, 9);
    p.sx = near_val(cx, s); p.sz = near_val(cz, s);
    p.ex = near_val(cx, s); p.ez = near_val(cz, s);
    p.ax = near_val(cx, s); p.az = near_val(cz, s);
    p.bx = near_val(cx, s); p.bz = near_val(cz, s);
    case (mode)
      0, 1: begin
        p = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom)};
      end
      2: begin
        p.ex = p.sx;
        p.ez = p.sz;
      end
      3: begin
        p.sz = coord_t'(cz); p.ez = coord_t'(cz);
        p.az = coord_t'(cz); p.bz = coord_t'(cz);
      end
      4: begin
        p.bx = p.ax;
        p.bz = p.az;
      end
      default: ;
    endcase
    return p;
  endfunction

  localparam coord_t MINC = -24'sd8388608;
  localparam coord_t MAXC = 24'sd8388607;

  row_t directed[] = '{
    // zero-length move far from the edge: move orientations zero, so it crosses
    '{'{0, 0, 0, 0, 1000, 1000, 2000, 1000}, 1, '{1, 1}},
    // collinear but disjoint segments still count as crossing
    '{'{0, 0, 10, 0, 5000, 0, 6000, 0}, 1, '{1, 1}},
    // well apart, not parallel
    '{'{0, 0, 10, 0, 5000, 5000, 5000, 6000}, 1, '{0, 0}},
    // end point inside the radius of the edge
    '{'{0, 500, 0, 50, -100, 0, 100, 0}, 1, '{1, 0}},
    // everything at the negative extreme
    '{'{MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC}, 1, '{1, 0}},
    // everything at the positive extreme
    '{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}, 1, '{1, 0}},
    // full-span diagonals crossing
    '{'{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC}, 1, '{1, 1}},
    // degenerate edge near the move's end
    '{'{0, 0, 300, 0, 350, 20, 350, 20}, 0, '{0, 0}},
    // vertex A near the middle of the move
    '{'{-500, 0, 500, 0, 0, 60, 0, 3000}, 0, '{0, 0}},
    // vertex B near the middle of the move
    '{'{-500, 0, 500, 0, 0, 3000, 30, -90}, 0, '{0, 0}},
    // exactly at the radius: strict compare must fail
    '{'{0, 1000, 0, 100, -100, 0, 100, 0}, 0, '{0, 0}},
    // opposite corners, long move, edge near the origin
    '{'{MAXC, MINC, MINC, MAXC, -5, 7, 9, -3}, 0, '{0, 0}}
  };

  initial begin
    hit_t h;
    int phase_pcts[5] = '{0, 66, 14, 66, 0};
    logic [RAD_WIDTH-1:0] phase_radii[5] = '{16'd0, 16'd65535, 16'd1, 16'd100, 16'd0};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table at the reset radius.
    foreach (directed[i]) begin
      if (directed[i].known) begin
        h = sweep_hits_edge(directed[i].p, radius);
        if (h.reaches != directed[i].want.reaches || h.crossed != directed[i].want.crossed)
          report_mismatch($sformatf("directed row %0d disagrees with predictor", i));
      end
      send_beat(directed[i].p);
    end

    // Random phases: radius and sender idling vary per phase.
    for (int ph = 0; ph < 5; ph++) begin
      phase_radii[4] = RAD_WIDTH'($urandom);
      set_radius(phase_radii[ph]);
      idle_pct = phase_pcts[ph];
      for (int n = 0; n < 370; n++) begin
        send_beat(random_probe());
        if (ph == 2 && n == 185) drain();
      end
    end

    drain();
    $display("Covered %0d beats over radii 0, 1, 100, 65535 and random;", beats_sent);
    $display("%0d reached, %0d by crossing.", hits_seen, cross_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== swept_circle_edge_test_top.f =====
sv/scet_pkg.sv
sv/scet_near.sv
sv/swept_circle_edge_test_top.sv
tb/sv/tb_swept_circle_edge_test_top.sv
